// ----- rtl/core/wgm_pkg.sv -----
package wgm_pkg;

  typedef logic [1:0] op_t;
  typedef logic [7:0] char_t;

  localparam op_t OP_APPEND = 2'd0;
  localparam op_t OP_CLEAR  = 2'd1;
  localparam op_t OP_SOURCE = 2'd2;
  localparam op_t OP_END    = 2'd3;

  localparam char_t STAR_CHAR = 8'h2A;
  localparam char_t ANY_CHAR  = 8'h3F;

  // one command issued from the input register to the state holders
  typedef struct packed {
    logic  en;
    op_t   op;
    char_t ch;
  } cmd_t;

endpackage

// ----- rtl/core/wgm_if.sv -----
interface wgm_in_if;
  logic             valid;
  logic             ready;
  wgm_pkg::op_t     op;
  wgm_pkg::char_t   ch;

  modport source (output valid, output op, output ch, input ready);
  modport sink   (input valid, input op, input ch, output ready);
endinterface

interface wgm_out_if;
  logic valid;
  logic ready;
  logic match;
  logic pattern_overflow;

  modport source (output valid, output match, output pattern_overflow, input ready);
  modport sink   (input valid, input match, input pattern_overflow, output ready);
endinterface

// ----- rtl/core/wildcard_glob_matcher_top.sv -----
// Streaming glob matcher: '*' matches any run of characters, '?' exactly one.
// Items enter at one per cycle with no gaps needed between pattern loads,
// source characters and end-of-source markers; only an end-of-source item
// waits, and holds back the input, while an earlier result is still unread in
// the output register. Each item is held in the input register and is applied
// to the pattern store and the live position vector in the cycle that it
// leaves it; an end-of-source result is loaded into the output register at
// the end of that cycle, and result valid is driven from that register. The
// per-cycle limit is the live vector update, whose star closure is a
// MAX_PAT+1 bit carry chain. A pattern longer than MAX_PAT sets
// pattern_overflow and forces match low until the pattern is cleared.
module wildcard_glob_matcher_top #(
  parameter int MAX_PAT = 32
) (
  input  logic      clk,
  input  logic      rst,
  wgm_in_if.sink    item,
  wgm_out_if.source result
);

  localparam int LW = $clog2(MAX_PAT + 1);

  logic            in_full;
  wgm_pkg::op_t    op_q;
  wgm_pkg::char_t  ch_q;
  logic            out_full;
  logic            match_q;
  logic            ovf_q;
  logic            fire;
  logic            is_end;
  wgm_pkg::cmd_t   cmd;
  logic [LW-1:0]   len;
  logic            ovf;
  logic [MAX_PAT-1:0] star_mask;
  logic [MAX_PAT-1:0] step_mask;
  logic [MAX_PAT:0]   closed;

  assign is_end = (op_q == wgm_pkg::OP_END);
  // only an end-of-source item needs room in the output register
  assign fire   = in_full && (!is_end || !out_full || result.ready);
  assign item.ready = !in_full || fire;

  assign cmd.en = fire;
  assign cmd.op = op_q;
  assign cmd.ch = ch_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (item.valid && item.ready) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      op_q <= item.op;
      ch_q <= item.ch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_full <= 1'b0;
    end else if (fire && is_end) begin
      out_full <= 1'b1;
    end else if (result.ready) begin
      out_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && is_end) begin
      match_q <= closed[len] && !ovf;
      ovf_q   <= ovf;
    end
  end

  assign result.valid            = out_full;
  assign result.match            = match_q;
  assign result.pattern_overflow = ovf_q;

  wgm_store #(
    .MAX_PAT (MAX_PAT),
    .LW      (LW)
  ) u_store (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .len       (len),
    .ovf       (ovf),
    .star_mask (star_mask),
    .step_mask (step_mask)
  );

  wgm_live #(
    .MAX_PAT (MAX_PAT)
  ) u_live (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .star_mask (star_mask),
    .step_mask (step_mask),
    .closed    (closed)
  );

  a_no_match_on_ovf: assert property (@(posedge clk) disable iff (rst)
    out_full && match_q |-> !ovf_q)
    else $error("match reported with pattern overflow");

  a_held_item: assert property (@(posedge clk) disable iff (rst)
    in_full && !fire |=> in_full && $stable(op_q) && $stable(ch_q))
    else $error("stalled item lost from input register");

  a_end_result: assert property (@(posedge clk) disable iff (rst)
    fire && is_end |=> out_full)
    else $error("end of source produced no result");

endmodule

// ----- rtl/core/wgm_store.sv -----
module wgm_store #(
  parameter int MAX_PAT = 32,
  parameter int LW      = $clog2(MAX_PAT + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  wgm_pkg::cmd_t       cmd,
  output logic [LW-1:0]       len,
  output logic                ovf,
  output logic [MAX_PAT-1:0]  star_mask,
  output logic [MAX_PAT-1:0]  step_mask
);

  wgm_pkg::char_t pat [MAX_PAT];
  logic append;
  logic clear;
  logic full;

  assign append = cmd.en && (cmd.op == wgm_pkg::OP_APPEND);
  assign clear  = cmd.en && (cmd.op == wgm_pkg::OP_CLEAR);
  assign full   = (len == LW'(MAX_PAT));

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
      ovf <= 1'b0;
    end else if (clear) begin
      len <= '0;
      ovf <= 1'b0;
    end else if (append) begin
      if (full) begin
        ovf <= 1'b1;
      end else begin
        len <= len + LW'(1);
      end
    end
  end

  // each entry written only when it is the next free slot
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PAT; i++) begin
      if (append && (len == LW'(i))) begin
        pat[i] <= cmd.ch;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_PAT; i++) begin
      star_mask[i] = (len > LW'(i)) && (pat[i] == wgm_pkg::STAR_CHAR);
      step_mask[i] = (len > LW'(i)) && (pat[i] != wgm_pkg::STAR_CHAR) &&
                     ((pat[i] == wgm_pkg::ANY_CHAR) || (pat[i] == cmd.ch));
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LW'(MAX_PAT))
    else $error("pattern length beyond storage");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    clear |=> (len == '0) && !ovf)
    else $error("clear did not empty the pattern");

endmodule

// ----- rtl/core/wgm_live.sv -----
module wgm_live #(
  parameter int MAX_PAT = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  wgm_pkg::cmd_t      cmd,
  input  logic [MAX_PAT-1:0] star_mask,
  input  logic [MAX_PAT-1:0] step_mask,
  output logic [MAX_PAT:0]   closed
);

  localparam int N = MAX_PAT + 1;

  logic [N-1:0] live;
  logic [N-1:0] live_next;
  logic [N-1:0] prop;
  logic [N-1:0] seed;
  logic [N-1:0] sum;
  logic [N-1:0] carries;

  // star closure as a carry chain: a live star passes liveness up through
  // a run of stars, exactly like a carry through propagate bits
  assign prop    = {1'b0, star_mask};
  assign seed    = live & prop;
  assign sum     = seed + prop;
  assign carries = sum ^ seed ^ prop;
  assign closed  = live | carries;

  always_comb begin
    live_next = live;
    if (cmd.en) begin
      unique case (cmd.op)
        wgm_pkg::OP_APPEND: live_next = live;
        wgm_pkg::OP_SOURCE: live_next = (closed & prop) |
                                        {step_mask & closed[MAX_PAT-1:0], 1'b0};
        wgm_pkg::OP_CLEAR,
        wgm_pkg::OP_END:    live_next = N'(1);
        default:            live_next = live;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= N'(1);
    end else begin
      live <= live_next;
    end
  end

  a_rearm: assert property (@(posedge clk) disable iff (rst)
    cmd.en && (cmd.op == wgm_pkg::OP_END || cmd.op == wgm_pkg::OP_CLEAR)
      |=> live == N'(1))
    else $error("vector not rearmed after end of source or clear");

endmodule

// ----- tb/sv/wildcard_glob_matcher_top_tb.sv -----
module wildcard_glob_matcher_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_PAT = 32;
  localparam int N_RANDOM_ITEMS = 500;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_START = 200;
  localparam int HOLD_CYCLES = 400;
  localparam wgm_pkg::char_t CH_A = 8'h61;
  localparam wgm_pkg::char_t CH_B = 8'h62;
  localparam wgm_pkg::char_t CH_X = 8'h78;
  localparam logic [MAX_PAT:0] LIVE_ARMED = {{MAX_PAT{1'b0}}, 1'b1};

  typedef struct {
    wgm_pkg::op_t   op;
    wgm_pkg::char_t ch;
  } glob_item_t;

  typedef struct packed {
    logic match;
    logic overflow;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  wgm_in_if  item_if ();
  wgm_out_if result_if ();

  wildcard_glob_matcher_top #(.MAX_PAT(MAX_PAT)) uut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_if),
    .result (result_if)
  );

  always #5 clk = ~clk;

  glob_item_t pending_items[$];
  verdict_t   expected_verdicts[$];
  int         queued_count = 0;
  int         error_count = 0;
  bit         hold_off = 1'b0;

  // matcher state as seen by the checker
  wgm_pkg::char_t   pat_store [MAX_PAT];
  int               pat_len = 0;
  logic [MAX_PAT:0] live_pos = LIVE_ARMED;
  logic             pat_ovf = 1'b0;

  // a live star also makes the following position live
  function automatic logic [MAX_PAT:0] star_closure(logic [MAX_PAT:0] v);
    logic [MAX_PAT:0] c;
    c = v;
    for (int i = 0; i < MAX_PAT; i++) begin
      if (i < pat_len && c[i] && pat_store[i] == wgm_pkg::STAR_CHAR) c[i+1] = 1'b1;
    end
    return c;
  endfunction

  task automatic apply_glob_item(wgm_pkg::op_t op, wgm_pkg::char_t ch);
    logic [MAX_PAT:0] cur;
    verdict_t v;
    case (op)
      wgm_pkg::OP_APPEND: begin
        if (pat_len < MAX_PAT) begin
          pat_store[pat_len] = ch;
          pat_len++;
        end else begin
          pat_ovf = 1'b1;
        end
      end
      wgm_pkg::OP_CLEAR: begin
        pat_len = 0;
        pat_ovf = 1'b0;
        live_pos = LIVE_ARMED;
      end
      wgm_pkg::OP_SOURCE: begin
        cur = star_closure(live_pos);
        live_pos = '0;
        for (int i = 0; i < pat_len; i++) begin
          if (cur[i]) begin
            if (pat_store[i] == wgm_pkg::STAR_CHAR) begin
              live_pos[i] = 1'b1;
            end else if (pat_store[i] == wgm_pkg::ANY_CHAR || pat_store[i] == ch) begin
              live_pos[i+1] = 1'b1;
            end
          end
        end
      end
      default: begin
        cur = star_closure(live_pos);
        v.match = cur[pat_len] && !pat_ovf;
        v.overflow = pat_ovf;
        expected_verdicts.insert(expected_verdicts.size(), v);
        live_pos = LIVE_ARMED;
      end
    endcase
  endtask

  task automatic queue_item(wgm_pkg::op_t op, wgm_pkg::char_t ch);
    glob_item_t it;
    it.op = op;
    it.ch = ch;
    pending_items.insert(pending_items.size(), it);
    queued_count++;
  endtask

  function automatic wgm_pkg::char_t pick_pattern_char();
    int r;
    r = $urandom_range(99);
    if (r < 35) return CH_A;
    if (r < 55) return CH_B;
    if (r < 72) return wgm_pkg::STAR_CHAR;
    if (r < 88) return wgm_pkg::ANY_CHAR;
    return wgm_pkg::char_t'($urandom_range(255));
  endfunction

  function automatic wgm_pkg::char_t pick_text_char();
    int r;
    r = $urandom_range(99);
    if (r < 40) return CH_A;
    if (r < 75) return CH_B;
    return wgm_pkg::char_t'($urandom_range(255));
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_idle();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 6);
  endfunction

  // source text built from the pattern so that most of them match
  task automatic queue_source(wgm_pkg::char_t pat[$]);
    if ($urandom_range(9) < 6) begin
      foreach (pat[i]) begin
        if (pat[i] == wgm_pkg::STAR_CHAR) begin
          repeat ($urandom_range(3)) queue_item(wgm_pkg::OP_SOURCE, pick_text_char());
        end else if (pat[i] == wgm_pkg::ANY_CHAR || $urandom_range(7) == 0) begin
          queue_item(wgm_pkg::OP_SOURCE, pick_text_char());
        end else begin
          queue_item(wgm_pkg::OP_SOURCE, pat[i]);
        end
      end
    end else begin
      repeat ($urandom_range(8)) queue_item(wgm_pkg::OP_SOURCE, pick_text_char());
    end
    if ($urandom_range(11) == 0) queue_item(wgm_pkg::OP_APPEND, pick_pattern_char());
    if ($urandom_range(15) != 0) begin
      queue_item(wgm_pkg::OP_END, wgm_pkg::char_t'($urandom_range(255)));
    end
  endtask

  task automatic queue_glob_round();
    wgm_pkg::char_t pat[$];
    int n;
    if ($urandom_range(14) == 0) n = $urandom_range(MAX_PAT + 2, MAX_PAT - 2);
    else n = $urandom_range(6);
    queue_item(wgm_pkg::OP_CLEAR, wgm_pkg::char_t'($urandom_range(255)));
    for (int i = 0; i < n; i++) begin
      pat.insert(pat.size(), pick_pattern_char());
      queue_item(wgm_pkg::OP_APPEND, pat[i]);
    end
    repeat ($urandom_range(4, 1)) queue_source(pat);
  endtask

  task automatic report_mismatch(string what, verdict_t exp_v, verdict_t got_v);
    error_count++;
    if (error_count <= 10)
      $display("%0t: %s: expected match=%0b overflow=%0b, got match=%0b overflow=%0b",
               $realtime, what, exp_v.match, exp_v.overflow, got_v.match, got_v.overflow);
  endtask

  // sender
  int send_gap = 0;
  int send_calm = 0;
  always @(posedge clk) begin
    glob_item_t it;
    if (rst) begin
      item_if.valid <= 1'b0;
    end else begin
      if (item_if.valid && item_if.ready) apply_glob_item(item_if.op, item_if.ch);
      if (!item_if.valid || item_if.ready) begin
        if (send_gap > 0) begin
          send_gap--;
          item_if.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          item_if.valid <= 1'b1;
          item_if.op <= it.op;
          item_if.ch <= it.ch;
          if (send_calm > 0) begin
            send_calm--;
          end else if ($urandom_range(29) == 0) begin
            send_calm = $urandom_range(60, 20);
          end else begin
            send_gap = pick_idle();
          end
        end else begin
          item_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  int stall_left = 0;
  int recv_calm = 0;
  always @(posedge clk) begin
    verdict_t got_v;
    verdict_t exp_v;
    if (rst) begin
      result_if.ready <= 1'b0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        got_v.match = result_if.match;
        got_v.overflow = result_if.pattern_overflow;
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result with none pending", '0, got_v);
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (got_v.match !== exp_v.match) report_mismatch("match", exp_v, got_v);
          if (got_v.overflow !== exp_v.overflow) report_mismatch("overflow", exp_v, got_v);
        end
      end
      if (hold_off) begin
        result_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= 1'b1;
        if (recv_calm > 0) recv_calm--;
        else if ($urandom_range(29) == 0) recv_calm = $urandom_range(60, 20);
        else stall_left = pick_idle();
      end
    end
  end

  // long hold-off on the result side so the input backs up
  initial begin
    @(negedge rst);
    repeat (HOLD_START) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #3ms;
    $display("wildcard_glob_matcher_top_tb: errors");
    $finish;
  end

  initial begin
    // empty pattern against empty source
    queue_item(wgm_pkg::OP_END, 8'hAA);
    // lone star: empty and one-character sources
    queue_item(wgm_pkg::OP_APPEND, wgm_pkg::STAR_CHAR);
    queue_item(wgm_pkg::OP_END, 8'h00);
    queue_item(wgm_pkg::OP_SOURCE, CH_X);
    queue_item(wgm_pkg::OP_END, 8'hFF);
    // byte zero and 0xff as literals, question mark on 0x01
    queue_item(wgm_pkg::OP_CLEAR, 8'hFF);
    queue_item(wgm_pkg::OP_APPEND, 8'h00);
    queue_item(wgm_pkg::OP_APPEND, 8'hFF);
    queue_item(wgm_pkg::OP_APPEND, wgm_pkg::ANY_CHAR);
    queue_item(wgm_pkg::OP_SOURCE, 8'h00);
    queue_item(wgm_pkg::OP_SOURCE, 8'hFF);
    queue_item(wgm_pkg::OP_SOURCE, 8'h01);
    queue_item(wgm_pkg::OP_END, 8'h55);
    // literal mismatch on the same pattern
    queue_item(wgm_pkg::OP_SOURCE, 8'h01);
    queue_item(wgm_pkg::OP_SOURCE, 8'hFF);
    queue_item(wgm_pkg::OP_SOURCE, 8'h01);
    queue_item(wgm_pkg::OP_END, 8'h00);
    // append while a source is in flight
    queue_item(wgm_pkg::OP_CLEAR, 8'h00);
    queue_item(wgm_pkg::OP_APPEND, CH_A);
    queue_item(wgm_pkg::OP_SOURCE, CH_A);
    queue_item(wgm_pkg::OP_APPEND, CH_B);
    queue_item(wgm_pkg::OP_SOURCE, CH_B);
    queue_item(wgm_pkg::OP_END, 8'h01);
    queue_item(wgm_pkg::OP_SOURCE, CH_A);
    queue_item(wgm_pkg::OP_END, 8'h80);

    while (queued_count < N_RANDOM_ITEMS + 25) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(4, 1)) begin
          queue_item(wgm_pkg::op_t'($urandom_range(3)), wgm_pkg::char_t'($urandom));
        end
      end else begin
        queue_glob_round();
      end
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() > 0 || item_if.valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0 && expected_verdicts.size() == 0) begin
      $display("wildcard_glob_matcher_top_tb: clean");
    end else begin
      $display("wildcard_glob_matcher_top_tb: errors");
    end
    $finish;
  end

endmodule

// ----- wildcard_glob_matcher_top.f -----
rtl/core/wgm_pkg.sv
rtl/core/wgm_if.sv
rtl/core/wgm_store.sv
rtl/core/wgm_live.sv
rtl/core/wildcard_glob_matcher_top.sv
tb/sv/wildcard_glob_matcher_top_tb.sv
